>>> rtl/rmie_pkg.sv
package rmie_pkg;

  localparam int unsigned OpWidth   = 4;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned AddrWidth = 10;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [OpWidth-1:0] {
    OP_MOV      = 4'd0,
    OP_LOAD     = 4'd1,
    OP_STORE    = 4'd2,
    OP_AND      = 4'd3,
    OP_OR       = 4'd4,
    OP_XOR      = 4'd5,
    OP_NOT      = 4'd6,
    OP_ADD      = 4'd7,
    OP_HOST_REG = 4'd8,
    OP_HOST_MEM = 4'd9
  } op_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

>>> rtl/rmie_ctrl.sv
module rmie_ctrl
  import rmie_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/rmie_datapath.sv
module rmie_datapath
  import rmie_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 1024,
  parameter int unsigned REG_COUNT = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  input  logic        [OpWidth-1:0]   op_i,
  input  logic        [RegIdxW-1:0]   dest_reg_i,
  input  logic        [RegIdxW-1:0]   src_reg_i,
  input  logic        [RegIdxW-1:0]   second_reg_i,
  input  logic        [AddrWidth-1:0] address_i,
  input  logic signed [DataWidth-1:0] write_value_i,
  output logic signed [DataWidth-1:0] value_o,
  output logic                        out_of_range_o
);

  localparam int unsigned MemAw = $clog2(MEM_DEPTH);
  localparam int unsigned RegAw = $clog2(REG_COUNT);
  localparam logic [RegIdxW:0]   RegLimit = (RegIdxW + 1)'(REG_COUNT);
  localparam logic [AddrWidth:0] MemLimit = (AddrWidth + 1)'(MEM_DEPTH);

  logic [DataWidth-1:0] regs_q [REG_COUNT];
  logic [DataWidth-1:0] mem_q  [MEM_DEPTH];

  logic [OpWidth-1:0]   op_q;
  logic [RegIdxW-1:0]   dest_q;
  logic                 dest_ok_q;
  logic [AddrWidth-1:0] addr_q;
  logic                 addr_ok_q;
  logic [DataWidth-1:0] opa_q, opb_q, rdata_q, wv_q;
  logic [DataWidth-1:0] value_q, value_d;
  logic                 oor_q, oor_d;
  logic                 reg_we, mem_we;

  logic                 src_ok, opb_ok, dest_ok, addr_ok;
  logic [RegIdxW-1:0]   opb_idx;

  assign opb_idx = (op_e'(op_i) == OP_ADD) ? second_reg_i : dest_reg_i;
  assign src_ok  = {1'b0, src_reg_i} < RegLimit;
  assign opb_ok  = {1'b0, opb_idx} < RegLimit;
  assign dest_ok = {1'b0, dest_reg_i} < RegLimit;
  assign addr_ok = {1'b0, address_i} < MemLimit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      dest_q    <= dest_reg_i;
      dest_ok_q <= dest_ok;
      addr_q    <= address_i;
      addr_ok_q <= addr_ok;
      wv_q      <= write_value_i;
      opa_q     <= src_ok ? regs_q[src_reg_i[RegAw-1:0]] : '0;
      opb_q     <= opb_ok ? regs_q[opb_idx[RegAw-1:0]] : '0;
    end
  end

  always_comb begin
    value_d = '0;
    oor_d   = 1'b0;
    reg_we  = 1'b0;
    mem_we  = 1'b0;
    case (op_e'(op_q))
      OP_MOV: begin
        value_d = opa_q;
        reg_we  = 1'b1;
      end
      OP_LOAD: begin
        if (addr_ok_q) begin
          value_d = rdata_q;
          reg_we  = 1'b1;
        end else begin
          oor_d = 1'b1;
        end
      end
      OP_STORE: begin
        if (addr_ok_q) begin
          value_d = opa_q;
          mem_we  = 1'b1;
        end else begin
          oor_d = 1'b1;
        end
      end
      OP_AND: begin
        value_d = opb_q & opa_q;
        reg_we  = 1'b1;
      end
      OP_OR: begin
        value_d = opb_q | opa_q;
        reg_we  = 1'b1;
      end
      OP_XOR: begin
        value_d = opb_q ^ opa_q;
        reg_we  = 1'b1;
      end
      OP_NOT: begin
        value_d = ~opa_q;
        reg_we  = 1'b1;
      end
      OP_ADD: begin
        value_d = opa_q + opb_q;
        reg_we  = 1'b1;
      end
      OP_HOST_REG: begin
        value_d = wv_q;
        reg_we  = 1'b1;
      end
      OP_HOST_MEM: begin
        if (addr_ok_q) begin
          value_d = wv_q;
          mem_we  = 1'b1;
        end else begin
          oor_d = 1'b1;
        end
      end
      default: begin
        value_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_q[i] <= '0;
      end
    end else if (cmd_i.commit && reg_we && dest_ok_q) begin
      regs_q[dest_q[RegAw-1:0]] <= value_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mem_we) begin
      mem_q[addr_q[MemAw-1:0]] <= value_d;
    end
    if (cmd_i.capture && addr_ok) begin
      rdata_q <= mem_q[address_i[MemAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      value_q <= value_d;
      oor_q   <= oor_d;
    end
  end

  assign value_o        = value_q;
  assign out_of_range_o = oor_q;

endmodule

>>> rtl/register_machine_instruction_execute.sv
// An accepted instruction word has its operands and memory word read and registered, then
// is executed and written back, which registers the result word; a new word is accepted only
// after that write back, and execution waits while the output register holds an untaken word.
// Reset: rst_ni clears the register file and the handshake state at once;
// data memory is not cleared and holds its contents only once written.
module register_machine_instruction_execute
  import rmie_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 1024,
  parameter int unsigned REG_COUNT = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic        [OpWidth-1:0]   op_i,
  input  logic        [RegIdxW-1:0]   dest_reg_i,
  input  logic        [RegIdxW-1:0]   src_reg_i,
  input  logic        [RegIdxW-1:0]   second_reg_i,
  input  logic        [AddrWidth-1:0] address_i,
  input  logic signed [DataWidth-1:0] write_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DataWidth-1:0] value_o,
  output logic                        out_of_range_o
);

  cmd_t cmd;

  rmie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rmie_datapath #(
    .MEM_DEPTH (MEM_DEPTH),
    .REG_COUNT (REG_COUNT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .dest_reg_i     (dest_reg_i),
    .src_reg_i      (src_reg_i),
    .second_reg_i   (second_reg_i),
    .address_i      (address_i),
    .write_value_i  (write_value_i),
    .value_o        (value_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule
